@@ hw/rtl/grid_ray_march_column_render_macros.svh @@
// Assertion macros for the grid ray march column renderer.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef GRID_RAY_MARCH_COLUMN_RENDER_MACROS_SVH
`define GRID_RAY_MARCH_COLUMN_RENDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GRMCR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grmcr: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GRMCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grmcr: next-cycle check failed");

`endif

@@ hw/rtl/grmcr_pkg.sv @@
// Package for the grid ray march column renderer: screen and step limits, sequencer states,
// cell kinds, glyph codes and register addresses. No dependencies.
package grmcr_pkg;

   localparam int unsigned SCREEN_ROWS = 40;
   localparam int unsigned MAX_STEPS   = 160;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_WATER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [6:0] GLYPH_SPACE = 7'h20;
   localparam logic [6:0] GLYPH_HASH  = 7'h23;
   localparam logic [6:0] GLYPH_DOT   = 7'h2E;
   localparam logic [6:0] GLYPH_DASH  = 7'h2D;
   localparam logic [6:0] GLYPH_X     = 7'h78;
   localparam logic [6:0] GLYPH_TILDE = 7'h7E;
   localparam logic [6:0] GLYPH_NONE  = 7'h00;

   localparam logic [2:0] CSR_PLAYER_X = 3'd0;
   localparam logic [2:0] CSR_PLAYER_Y = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSTEP,
      ST_MWAIT,
      ST_MCHK,
      ST_NC,
      ST_NCFIN,
      ST_ROW,
      ST_WALL,
      ST_FMUL,
      ST_FNEG,
      ST_FDY,
      ST_FRD,
      ST_FWAIT,
      ST_FCHK,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

@@ hw/rtl/grid_ray_march_column_render.sv @@
// A cast marches the ray in 0.1-unit steps (up to MAX_STEPS), each through the
// states MSTEP, MWAIT and MCHK, then does the horizon division, then each row: one
// shared restoring divider serves every row division. Requests are taken only while
// idle, one word at a time; a map word is stored when taken, a cast gives 40 words.
// Reset (synchronous, active high) clears the sequencer and player registers;
// the map store is not cleared and must be written before any cast.
`include "grid_ray_march_column_render_macros.svh"

module grid_ray_march_column_render
   import grmcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dir_x[15:0], dir_y[31:16], cell_index[39:32], cell_kind[41:40], zero pad
   input  logic [47:0] req_tdata,
   // mode[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row[5:0], glyph[12:6], zero pad
   output logic [15:0] rsp_tdata,
   // write[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [15:0]        px_ff, py_ff;
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [23:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [7:0]         k_ff, k_in;
   logic [7:0]         d_ff, d_in;
   logic signed [9:0]  nc_ff, nc_in;
   logic [5:0]         y_ff, y_in;
   logic signed [24:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [3:0]         cx_ff, cx_in;
   logic [12:0]        dnum_ff, dnum_in;
   logic [9:0]         dden_ff, dden_in;
   logic [10:0]        drem_ff, drem_in;
   logic [3:0]         dcnt_ff, dcnt_in;
   logic [6:0]         glyph_ff, glyph_in;
   logic               wr_ff, wr_in;
   logic [7:0]         rd_addr_ff, rd_addr_in;
   logic [1:0]         map_q_ff;
   logic [1:0]         map_mem [0:255];

   logic req_fire, csr_wr;

   // The ray position is held as 40 times the Q4.12 value so that one map unit
   // is 163840 = 5 * 2^15; the cell is the position shifted by 15, divided by 5.
   typedef struct packed {
      logic       out;
      logic [3:0] idx;
   } cell_type;

   function automatic cell_type cell_of(input logic signed [23:0] a);
      cell_type   c;
      logic [15:0] prod;
      logic [5:0]  q;
      c    = '0;
      prod = 16'(a[22:15]) * 16'd205;
      q    = prod[15:10];
      if (a[23]) begin
         c.out = (a <= -24'sd163840);
      end else begin
         c.out = (q >= 6'd16);
         c.idx = q[3:0];
      end
      return c;
   endfunction

   cell_type cell_x, cell_y;
   assign cell_x = cell_of(ax_ff);
   assign cell_y = cell_of(ay_ff);

   // Shared divider step.
   logic [10:0] div_shift;
   logic        div_take;
   assign div_shift = {drem_ff[9:0], dnum_ff[12]};
   assign div_take  = (div_shift >= {1'b0, dden_ff});

   // Horizon terms.
   logic signed [8:0] dm;
   logic [7:0]        dmag;
   logic signed [9:0] ys, nf, ymn;
   logic signed [10:0] span;
   assign dm   = $signed({1'b0, d_ff}) - 9'sd20;
   assign dmag = dm[8] ? 8'(-dm) : dm[7:0];
   assign ys   = $signed({4'd0, y_ff});
   assign nf   = 10'sd40 - nc_ff;
   assign ymn  = ys - nc_ff;
   assign span = 11'sd40 - ($signed({nc_ff[9], nc_ff}) <<< 1);

   // Texture column: (d*8/10) mod 8 as (4d*205 >> 10) mod 8.
   logic [17:0] tx_prod;
   logic [2:0]  tx;
   assign tx_prod = 18'({d_ff, 2'b00}) * 18'd205;
   assign tx      = tx_prod[12:10];

   // Floor terms: q = 2y - 40, den = q * 2^14.
   logic [5:0]         fq;
   logic [6:0]         fq_w;
   logic signed [24:0] fden, dxe, dye, nx_neg, ny_neg;
   logic signed [27:0] tex_x, tex_y;
   logic [21:0]        pxq, pyq;
   assign fq_w   = {y_ff, 1'b0} - 7'd40;
   assign fq     = fq_w[5:0];
   assign fden   = $signed({5'd0, fq, 14'd0});
   assign pxq    = 22'(px_ff) * 22'(fq);
   assign pyq    = 22'(py_ff) * 22'(fq);
   assign dxe    = $signed({{9{dx_ff[15]}}, dx_ff});
   assign dye    = $signed({{9{dy_ff[15]}}, dy_ff});
   assign nx_neg = nx_ff + fden;
   assign ny_neg = ny_ff + fden;
   assign tex_x  = ($signed({{3{nx_ff[24]}}, nx_ff}) <<< 3) + $signed({3'd0, fden});
   assign tex_y  = ($signed({{3{ny_ff[24]}}, ny_ff}) <<< 3) + $signed({3'd0, fden});

   // Floor shading by SCREEN_ROWS minus the row number.
   logic [5:0] fdist;
   logic [6:0] shade;
   assign fdist = 6'(SCREEN_ROWS) - y_ff;
   always_comb begin
      if ((9'(fdist) << 3) < 9'd40) begin
         shade = GLYPH_HASH;
      end else if ((9'(fdist) << 2) < 9'd40) begin
         shade = GLYPH_X;
      end else if ((9'(fdist) << 3) < 9'd120) begin
         shade = GLYPH_DOT;
      end else if (10'(fdist) * 10'd20 < 10'd360) begin
         shade = GLYPH_DASH;
      end else begin
         shade = GLYPH_SPACE;
      end
   end

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {16'd0, py_ff} : {16'd0, px_ff};

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {3'd0, glyph_ff, y_ff};
   assign rsp_tuser  = wr_ff;
   assign rsp_tlast  = (y_ff == 6'(SCREEN_ROWS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_tuser[0]) begin
               state_in = ST_MSTEP;
            end
         end
         ST_MSTEP: begin
            state_in = (cell_x.out || cell_y.out) ? ST_NC : ST_MWAIT;
         end
         ST_MWAIT: state_in = ST_MCHK;
         ST_MCHK: begin
            if (map_q_ff == KIND_WALL || k_ff == 8'(MAX_STEPS)) begin
               state_in = ST_NC;
            end else begin
               state_in = ST_MSTEP;
            end
         end
         ST_NC:    state_in = ST_DIV;
         ST_NCFIN: state_in = ST_ROW;
         ST_ROW: begin
            if (ys <= nc_ff) begin
               state_in = ST_OUT;
            end else if (ys <= nf) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FMUL;
            end
         end
         ST_WALL: state_in = ST_OUT;
         ST_FMUL: state_in = ST_FNEG;
         ST_FNEG: begin
            state_in = (nx_neg <= 0 || ny_neg <= 0) ? ST_OUT : ST_DIV;
         end
         ST_FDY:   state_in = ST_DIV;
         ST_FRD:   state_in = ST_FWAIT;
         ST_FWAIT: state_in = ST_FCHK;
         ST_FCHK:  state_in = ST_OUT;
         ST_DIV: begin
            if (dcnt_ff == 4'd0) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = rsp_tlast ? ST_IDLE : ST_ROW;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output values.
   always_comb begin
      ret_in     = ret_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      k_in       = k_ff;
      d_in       = d_ff;
      nc_in      = nc_ff;
      y_in       = y_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      cx_in      = cx_ff;
      dnum_in    = dnum_ff;
      dden_in    = dden_ff;
      drem_in    = drem_ff;
      dcnt_in    = dcnt_ff;
      glyph_in   = glyph_ff;
      wr_in      = wr_ff;
      rd_addr_in = rd_addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            dx_in = $signed(req_tdata[15:0]);
            dy_in = $signed(req_tdata[31:16]);
            ax_in = $signed(({8'd0, px_ff} << 5) + ({8'd0, px_ff} << 3))
                    + $signed({{8{req_tdata[15]}}, req_tdata[15:0]});
            ay_in = $signed(({8'd0, py_ff} << 5) + ({8'd0, py_ff} << 3))
                    + $signed({{8{req_tdata[31]}}, req_tdata[31:16]});
            k_in  = 8'd1;
         end
         ST_MSTEP: begin
            d_in       = 8'(MAX_STEPS);
            rd_addr_in = {cell_x.idx, cell_y.idx};
         end
         ST_MCHK: begin
            if (map_q_ff == KIND_WALL) begin
               d_in = k_ff;
            end
            k_in  = k_ff + 8'd1;
            ax_in = ax_ff + $signed({{8{dx_ff[15]}}, dx_ff});
            ay_in = ay_ff + $signed({{8{dy_ff[15]}}, dy_ff});
         end
         ST_NC: begin
            dnum_in = 13'(dmag) * 13'd40;
            dden_in = {1'b0, d_ff, 1'b0};
            drem_in = '0;
            dcnt_in = 4'd12;
            ret_in  = ST_NCFIN;
         end
         ST_NCFIN: begin
            nc_in = dm[8] ? -$signed({1'b0, dnum_ff[8:0]}) : $signed({1'b0, dnum_ff[8:0]});
            y_in  = '0;
         end
         ST_ROW: begin
            glyph_in = GLYPH_SPACE;
            wr_in    = 1'b1;
            dnum_in  = {ymn[9:0], 3'b000};
            dden_in  = span[9:0];
            drem_in  = '0;
            dcnt_in  = 4'd12;
            ret_in   = ST_WALL;
         end
         ST_WALL: begin
            if (dnum_ff >= 13'd8) begin
               glyph_in = GLYPH_SPACE;
            end else if (dnum_ff == 13'd0 || dnum_ff == 13'd7 || tx == 3'd0 || tx == 3'd7) begin
               glyph_in = GLYPH_HASH;
            end else begin
               glyph_in = GLYPH_DOT;
            end
         end
         ST_FMUL: begin
            nx_in = $signed({1'b0, pxq, 2'b00}) + (dxe <<< 5) + (dxe <<< 3);
            ny_in = $signed({1'b0, pyq, 2'b00}) + (dye <<< 5) + (dye <<< 3);
         end
         ST_FNEG: begin
            glyph_in = GLYPH_NONE;
            wr_in    = 1'b0;
            dnum_in  = nx_ff[24] ? 13'd0 : 13'(nx_ff[23:14]);
            dden_in  = 10'(fq);
            drem_in  = '0;
            dcnt_in  = 4'd12;
            ret_in   = ST_FDY;
         end
         ST_FDY: begin
            cx_in   = dnum_ff[3:0];
            dnum_in = ny_ff[24] ? 13'd0 : 13'(ny_ff[23:14]);
            dden_in = 10'(fq);
            drem_in = '0;
            dcnt_in = 4'd12;
            ret_in  = ST_FRD;
         end
         ST_FRD: begin
            rd_addr_in = {cx_ff, dnum_ff[3:0]};
         end
         ST_FCHK: begin
            if (map_q_ff == KIND_WATER) begin
               if (tex_x <= 0 || tex_y <= 0) begin
                  glyph_in = GLYPH_NONE;
                  wr_in    = 1'b0;
               end else begin
                  glyph_in = GLYPH_TILDE;
                  wr_in    = 1'b1;
               end
            end else begin
               glyph_in = shade;
               wr_in    = 1'b1;
            end
         end
         ST_DIV: begin
            drem_in = div_take ? (div_shift - {1'b0, dden_ff}) : div_shift;
            dnum_in = {dnum_ff[11:0], div_take};
            dcnt_in = dcnt_ff - 4'd1;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               y_in = y_ff + 6'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         px_ff    <= '0;
         py_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (csr_wr && csr_paddr[2] == CSR_PLAYER_X[2]) begin
            px_ff <= csr_pwdata[15:0];
         end
         if (csr_wr && csr_paddr[2] == CSR_PLAYER_Y[2]) begin
            py_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      k_ff       <= k_in;
      d_ff       <= d_in;
      nc_ff      <= nc_in;
      y_ff       <= y_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      cx_ff      <= cx_in;
      dnum_ff    <= dnum_in;
      dden_ff    <= dden_in;
      drem_ff    <= drem_in;
      dcnt_ff    <= dcnt_in;
      glyph_ff   <= glyph_in;
      wr_ff      <= wr_in;
      rd_addr_ff <= rd_addr_in;
   end

   // Map store: one write port for map words, one registered read port.
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser[0]) begin
         map_mem[req_tdata[39:32]] <= req_tdata[41:40];
      end
      map_q_ff <= map_mem[rd_addr_ff];
   end

   `GRMCR_ASSERT_NOW(a_idle_no_result, req_tready, !rsp_tvalid)
   `GRMCR_ASSERT_NOW(a_div_nonzero, state_ff == ST_DIV, dden_ff != 10'd0)
   `GRMCR_ASSERT_NEXT(a_last_to_idle, rsp_tvalid && rsp_tready && rsp_tlast, req_tready)

endmodule

@@ tb/grid_ray_march_column_render_tb.sv @@
// Self-checking bench for the grid ray march column renderer: loads maps, casts rays
// and compares every row word against a behavioural predictor. Depends on grmcr_pkg and the renderer.
`timescale 1ns / 100ps

module grid_ray_march_column_render_tb;
   import grmcr_pkg::*;

   // Result word as the predictor sees it.
   typedef struct packed {
      logic [5:0] row;
      logic [6:0] glyph;
      logic       wr;
      logic       last;
   } glyph_word_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // The bench's own copy of the block's state.
   logic [1:0]  grid_model [256];
   logic [15:0] pos_row;
   logic [15:0] pos_col;

   glyph_word_type pending_glyphs[$];
   int          mismatch_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          recv_hold;

   grid_ray_march_column_render dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Integer division truncating toward zero, whatever the signs.
   function automatic longint tdiv(longint a, longint b);
      longint q;
      q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic longint tmod(longint a, longint b);
      return a - tdiv(a, b) * b;
   endfunction

   // Marches the ray in tenths of a unit and returns the distance to the first wall, or MAX_STEPS if none.
   function automatic int march_depth(longint dx, longint dy);
      longint rx, ry;
      for (int k = 1; k <= MAX_STEPS; k++) begin
         rx = tdiv(longint'(pos_row) * 40 + dx * k, 163840);
         ry = tdiv(longint'(pos_col) * 40 + dy * k, 163840);
         if (rx < 0 || rx > 15 || ry < 0 || ry > 15) return MAX_STEPS;
         if (grid_model[rx * 16 + ry] == KIND_WALL) return k;
      end
      return MAX_STEPS;
   endfunction

   function automatic logic [6:0] floor_glyph(longint y);
      longint d;
      d = 40 - y;
      if (8 * d < 40) return GLYPH_HASH;
      if (4 * d < 40) return GLYPH_X;
      if (8 * d < 120) return GLYPH_DOT;
      if (20 * d < 360) return GLYPH_DASH;
      return GLYPH_SPACE;
   endfunction

   // Works out the forty row words that one cast produces.
   task automatic predict_column(logic signed [15:0] dir_r, logic signed [15:0] dir_c);
      longint d, nc, nf, ty, tx, q, den, nx, ny, cx, cy;
      glyph_word_type w;
      d  = march_depth(dir_r, dir_c);
      nc = tdiv(40 * (d - 20), 2 * d);
      nf = 40 - nc;
      for (longint y = 0; y < 40; y++) begin
         w.row = y[5:0];
         w.wr = 1'b1;
         w.last = (y == 39);
         w.glyph = GLYPH_SPACE;
         if (y > nc && y <= nf) begin
            ty = tdiv(8 * (y - nc), nf - nc);
            tx = tmod(tdiv(d * 8, 10), 8);
            if (ty < 8)
               w.glyph = (ty == 0 || ty == 7 || tx == 0 || tx == 7) ? GLYPH_HASH : GLYPH_DOT;
         end else if (y > nf) begin
            q   = 2 * y - 40;
            den = 16384 * q;
            nx  = 4 * longint'(pos_row) * q + 40 * longint'(dir_r);
            ny  = 4 * longint'(pos_col) * q + 40 * longint'(dir_c);
            cx  = tmod(tdiv(nx, den), 16);
            cy  = tmod(tdiv(ny, den), 16);
            if (cx < 0 || cy < 0) begin
               w.wr = 1'b0;
               w.glyph = GLYPH_NONE;
            end else if (grid_model[cx * 16 + cy] == KIND_WATER) begin
               if (tmod(tdiv(nx * 8, den), 8) < 0 || tmod(tdiv(ny * 8, den), 8) < 0) begin
                  w.wr = 1'b0;
                  w.glyph = GLYPH_NONE;
               end else begin
                  w.glyph = GLYPH_TILDE;
               end
            end else begin
               w.glyph = floor_glyph(y);
            end
         end
         pending_glyphs.push_back(w);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Offers one word, honouring the sender's idle percentage, and predicts at acceptance.
   // Valid stays high after acceptance so that the next word can follow directly; an idle
   // cycle or a drain drops it.
   task automatic send_word(bit is_map, logic signed [15:0] dr, logic signed [15:0] dc,
                            logic [7:0] idx, logic [1:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_map;
      req_tdata  <= {6'd0, kind, idx, dc, dr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (is_map) grid_model[idx] = kind;
      else predict_column(dr, dc);
   endtask

   task automatic write_cell(int idx, logic [1:0] kind);
      send_word(1'b1, 16'sd0, 16'sd0, idx[7:0], kind);
   endtask

   task automatic cast_ray(logic signed [15:0] dr, logic signed [15:0] dc);
      send_word(1'b0, dr, dc, 8'($urandom), 2'($urandom));
   endtask

   // Drops valid, waits for every predicted word, then the drain time of a map write.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] addr, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_PLAYER_X) pos_row = value;
      else pos_col = value;
      @(posedge clock);
   endtask

   task automatic place_player(logic [15:0] r, logic [15:0] c);
      drain_all();
      write_register(CSR_PLAYER_X, r);
      write_register(CSR_PLAYER_Y, c);
   endtask

   // Fills the whole store with random cells, with a border of walls when border is set.
   task automatic load_map(int wall_pct, bit border);
      logic [1:0] k;
      for (int i = 0; i < 256; i++) begin
         k = ($urandom_range(99) < wall_pct) ? KIND_WALL : 2'($urandom_range(3));
         if (k == KIND_WALL && $urandom_range(1)) k = KIND_EMPTY;
         if (border && (i < 16 || i > 239 || i % 16 == 0 || i % 16 == 15)) k = KIND_WALL;
         write_cell(i, k);
      end
   endtask

   // Rewrites count random cells of the already loaded store.
   task automatic scatter_cells(int count, int wall_pct);
      logic [1:0] k;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(99) < wall_pct) ? KIND_WALL : 2'($urandom_range(3));
         write_cell($urandom_range(255), k);
      end
   endtask

   function automatic logic signed [15:0] rand_dir();
      return 16'(int'($urandom_range(32768)) - 16384);
   endfunction

   // Directed part: extreme directions, wall, water and spare cell writes, player extremes.
   task automatic test_directed();
      load_map(0, 1'b0);
      write_cell(17, KIND_WALL);
      write_cell(100, KIND_WATER);
      write_cell(101, KIND_SPARE);
      place_player(16'h8000, 16'h8000);
      cast_ray(16'sd16384, 16'sd0);
      cast_ray(-16'sd16384, 16'sd0);
      cast_ray(16'sd0, 16'sd16384);
      cast_ray(16'sd0, -16'sd16384);
      cast_ray(16'sd11585, 16'sd11585);
      cast_ray(-16'sd11585, -16'sd11585);
      cast_ray(16'sd0, 16'sd0);
      cast_ray(16'sh8000, 16'sh7fff);
      place_player(16'h0000, 16'h0000);
      cast_ray(16'sd11585, 16'sd11585);
      cast_ray(-16'sd16384, 16'sd16384);
      place_player(16'hffff, 16'hffff);
      cast_ray(-16'sd11585, -16'sd11585);
      cast_ray(16'sd16384, 16'sd0);
      place_player(16'h1800, 16'h1800);
      cast_ray(-16'sd11585, 16'sd0);
   endtask

   // Random rays with occasional random cell writes, placing the player anew every twelfth cast.
   task automatic test_random(int casts);
      for (int i = 0; i < casts; i++) begin
         if (i % 12 == 0) place_player(16'($urandom), 16'($urandom));
         if ($urandom_range(9) == 0) write_cell($urandom_range(255), 2'($urandom));
         cast_ray(rand_dir(), rand_dir());
      end
   endtask

   // Receiver holds off long while the sender keeps offering casts, stalling the block's output.
   task automatic test_back_pressure();
      recv_hold = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            recv_hold = 1'b0;
         end
         repeat (4) cast_ray(rand_dir(), rand_dir());
      join
   endtask

   // Result checker: compares each accepted word against the oldest prediction.
   always @(posedge clock) begin
      glyph_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_glyphs.size() == 0) begin
            report_mismatch("unexpected word, row", rsp_tdata[5:0], -1);
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_tdata[5:0] != want.row) report_mismatch("row", rsp_tdata[5:0], want.row);
            if (rsp_tdata[12:6] != want.glyph)
               report_mismatch("glyph", rsp_tdata[12:6], want.glyph);
            if (rsp_tuser[0] != want.wr) report_mismatch("write", rsp_tuser[0], want.wr);
            if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   // Receiver readiness, redrawn at every edge.
   always @(posedge clock) begin
      rsp_tready <= !reset && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      recv_hold = 1'b0;
      pos_row = '0;
      pos_col = '0;
      for (int i = 0; i < 256; i++) grid_model[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      scatter_cells(16, 40);
      test_random(20);
      send_idle_pct = 74;
      test_random(15);
      send_idle_pct = 0;
      recv_stall_pct = 74;
      scatter_cells(16, 60);
      test_random(15);
      send_idle_pct = 11;
      recv_stall_pct = 11;
      test_random(15);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_back_pressure();
      test_random(10);
      drain_all();
      repeat (50) @(posedge clock);

      if (mismatch_count == 0 && pending_glyphs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/grmcr_pkg.sv
hw/rtl/grid_ray_march_column_render.sv
tb/grid_ray_march_column_render_tb.sv
